### rtl/all_pairs_shortest_path_engine_defines.svh
// Assertion macros shared by the shortest path engine RTL.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef ALL_PAIRS_SHORTEST_PATH_ENGINE_DEFINES_SVH
`define ALL_PAIRS_SHORTEST_PATH_ENGINE_DEFINES_SVH
`ifndef SYNTHESIS
`define APSP_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("apsp check failed");
`define APSP_NEVER(lbl, cond) `APSP_ASSERT(lbl, !(cond))
`else
`define APSP_ASSERT(lbl, prop)
`define APSP_NEVER(lbl, cond)
`endif
`endif

### rtl/apsp_pkg.sv
// Shared constants, types and the controller-to-datapath command struct
// for the shortest path engine. No dependencies.
`timescale 1ns / 1ps
package apsp_pkg;
    localparam int MAX_NODES = 256;
    localparam int NODE_W    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int ADDR_W    = 2 * NODE_W;
    localparam int CNT_W     = $clog2(MAX_NODES + 1);
    localparam int CFG_W     = 9;
    localparam int CMP_W     = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int DIST_W    = 41;
    localparam int LEN_W     = 40;
    localparam int WGT_W     = 32;
    localparam int REQ_W     = 2;
    localparam int PORT_NODE_W = 8;

    localparam logic [DIST_W-1:0] DIST_INF = {1'b1, {LEN_W{1'b0}}};

    typedef enum logic [REQ_W-1:0] {
        REQ_SET     = 2'd0,
        REQ_CLOSURE = 2'd1,
        REQ_INSERT  = 2'd2,
        REQ_QUERY   = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        CAP_NONE = 3'd0,
        CAP_ZERO = 3'd1,
        CAP_EDGE = 3'd2,
        CAP_S    = 3'd3,
        CAP_C    = 3'd4
    } t_cap;

    typedef enum logic [2:0] {
        WS_INIT   = 3'd0,
        WS_WEIGHT = 3'd1,
        WS_EDGE_A = 3'd2,
        WS_EDGE_B = 3'd3,
        WS_RELAX  = 3'd4
    } t_wsel;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr_a;
        logic [ADDR_W-1:0] rd_addr_b;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        t_wsel             wr_sel;
        t_cap              cap;
        logic              ld_w;
        logic              q_out;
        logic              q_ok;
    } t_dp_cmd;
endpackage

### rtl/apsp_dpath.sv
// Datapath: distance matrix memory, saturating adders, relax compare.
// Depends on apsp_pkg and all_pairs_shortest_path_engine_defines.svh; driven by apsp_ctrl commands.
`timescale 1ns / 1ps
`include "all_pairs_shortest_path_engine_defines.svh"
module apsp_dpath import apsp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    input  logic [WGT_W-1:0]  i_edge_weight,
    output logic [LEN_W-1:0]  o_path_length,
    output logic              o_unreachable,
    output logic              o_valid
);
    function automatic logic [DIST_W-1:0] sat_add(input logic [DIST_W-1:0] x,
                                                  input logic [DIST_W-1:0] y);
        logic [DIST_W:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (x[DIST_W-1] || y[DIST_W-1] || s[DIST_W] || s[DIST_W-1])
            return DIST_INF;
        return s[DIST_W-1:0];
    endfunction

    function automatic logic [DIST_W-1:0] dmin(input logic [DIST_W-1:0] x,
                                               input logic [DIST_W-1:0] y);
        return (y < x) ? y : x;
    endfunction

    logic [DIST_W-1:0] r_mem [0:(1 << ADDR_W)-1];
    logic [DIST_W-1:0] r_rda, r_rdb;
    logic [DIST_W-1:0] r_mab, r_mba, r_s1, r_s2, r_c1, r_c2;
    logic [WGT_W-1:0]  r_w;
    logic [DIST_W-1:0] n_wdata, w_ext;
    logic [LEN_W-1:0]  r_len;
    logic              r_unr, r_valid;

    assign w_ext = DIST_W'(r_w);

    always_comb begin
        case (i_cmd.wr_sel)
            WS_INIT: begin
                n_wdata = (i_cmd.wr_addr[ADDR_W-1:NODE_W] == i_cmd.wr_addr[NODE_W-1:0])
                          ? '0 : DIST_INF;
            end
            WS_WEIGHT: n_wdata = w_ext;
            WS_EDGE_A: n_wdata = dmin(r_rda, w_ext);
            WS_EDGE_B: n_wdata = r_mba;
            WS_RELAX:  n_wdata = dmin(dmin(r_rda, r_c1), r_c2);
            default:   n_wdata = DIST_INF;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_cmd.wr_addr] <= n_wdata;
        end
        if (i_cmd.rd_en) begin
            r_rda <= r_mem[i_cmd.rd_addr_a];
            r_rdb <= r_mem[i_cmd.rd_addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_w) begin
            r_w <= i_edge_weight;
        end
        case (i_cmd.cap)
            CAP_ZERO: begin
                r_mab <= '0;
                r_mba <= '0;
            end
            CAP_EDGE: begin
                r_mab <= dmin(r_rda, w_ext);
                r_mba <= dmin(r_rdb, w_ext);
            end
            CAP_S: begin
                r_s1 <= sat_add(r_rda, r_mab);
                r_s2 <= sat_add(r_rdb, r_mba);
            end
            CAP_C: begin
                r_c1 <= sat_add(r_s1, r_rda);
                r_c2 <= sat_add(r_s2, r_rdb);
            end
            default: ;
        endcase
        if (i_cmd.q_out) begin
            if (i_cmd.q_ok && !r_rda[DIST_W-1]) begin
                r_len <= r_rda[LEN_W-1:0];
                r_unr <= 1'b0;
            end else begin
                r_len <= '0;
                r_unr <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.q_out;
        end
    end

    assign o_path_length = r_len;
    assign o_unreachable = r_unr;
    assign o_valid       = r_valid;

    `APSP_ASSERT(a_valid_single, o_valid |=> !o_valid)
    `APSP_ASSERT(a_unr_zero, o_valid && o_unreachable |-> o_path_length == '0)
    `APSP_ASSERT(a_valid_cause, o_valid |-> $past(i_cmd.q_out))
endmodule

### rtl/apsp_ctrl.sv
// Controller: request decode, loop counters and the per-entry sequencer.
// Depends on apsp_pkg and all_pairs_shortest_path_engine_defines.svh; issues t_dp_cmd to apsp_dpath.
`timescale 1ns / 1ps
`include "all_pairs_shortest_path_engine_defines.svh"
module apsp_ctrl import apsp_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [REQ_W-1:0]       i_req_type,
    input  logic [PORT_NODE_W-1:0] i_node_a,
    input  logic [PORT_NODE_W-1:0] i_node_b,
    input  logic                   i_cfg_valid,
    input  logic [CFG_W-1:0]       i_cfg_data,
    output logic                   o_cfg_ready,
    output logic                   o_busy,
    output t_dp_cmd                o_cmd
);
    typedef enum logic [12:0] {
        S_CLEAR   = 13'b0000000000001,
        S_IDLE    = 13'b0000000000010,
        S_SET_AB  = 13'b0000000000100,
        S_SET_BA  = 13'b0000000001000,
        S_INS_RD  = 13'b0000000010000,
        S_INS_WA  = 13'b0000000100000,
        S_INS_WB  = 13'b0000001000000,
        S_P0      = 13'b0000010000000,
        S_P1      = 13'b0000100000000,
        S_P2      = 13'b0001000000000,
        S_P3      = 13'b0010000000000,
        S_QRY_RD  = 13'b0100000000000,
        S_QRY_OUT = 13'b1000000000000
    } t_state;

    function automatic logic [ADDR_W-1:0] addr(input logic [NODE_W-1:0] row,
                                               input logic [NODE_W-1:0] col);
        return {row, col};
    endfunction

    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_clr, n_clr;
    logic [CFG_W-1:0]  r_active;
    logic [NODE_W-1:0] r_a, n_a, r_b, n_b, r_i, n_i, r_j, n_j, r_k, n_k;
    logic              r_ok, n_ok, r_clo, n_clo;
    logic [CMP_W-1:0]  eff, last;
    logic              in_range, i_last, j_last, k_last;
    logic [NODE_W-1:0] rk_a, rk_b;
    t_req              req;

    assign req      = t_req'(i_req_type);
    assign eff      = (CMP_W'(r_active) > CMP_W'(MAX_NODES)) ? CMP_W'(MAX_NODES)
                                                             : CMP_W'(r_active);
    assign last     = eff - CMP_W'(1);
    assign in_range = (CMP_W'(i_node_a) < eff) && (CMP_W'(i_node_b) < eff);
    assign i_last   = (CMP_W'(r_i) == last);
    assign j_last   = (CMP_W'(r_j) == last);
    assign k_last   = (CMP_W'(r_k) == last);
    assign rk_a     = r_clo ? r_k : r_a;
    assign rk_b     = r_clo ? r_k : r_b;

    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        n_a     = r_a;
        n_b     = r_b;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        n_ok    = r_ok;
        n_clo   = r_clo;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_addr = r_clr;
                o_cmd.wr_sel  = WS_INIT;
                n_clr         = r_clr + ADDR_W'(1);
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.ld_w = 1'b1;
                    n_a  = NODE_W'(i_node_a);
                    n_b  = NODE_W'(i_node_b);
                    n_ok = in_range;
                    n_i  = '0;
                    n_j  = '0;
                    n_k  = '0;
                    unique case (req)
                        REQ_SET: begin
                            if (in_range && i_node_a != i_node_b) n_state = S_SET_AB;
                        end
                        REQ_CLOSURE: begin
                            o_cmd.cap = CAP_ZERO;
                            n_clo     = 1'b1;
                            if (eff != '0) n_state = S_P0;
                        end
                        REQ_INSERT: begin
                            n_clo = 1'b0;
                            if (in_range && i_node_a != i_node_b) n_state = S_INS_RD;
                        end
                        REQ_QUERY: n_state = S_QRY_RD;
                        default: ;
                    endcase
                end
            end
            S_SET_AB: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_addr = addr(r_a, r_b);
                o_cmd.wr_sel  = WS_WEIGHT;
                n_state       = S_SET_BA;
            end
            S_SET_BA: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_addr = addr(r_b, r_a);
                o_cmd.wr_sel  = WS_WEIGHT;
                n_state       = S_IDLE;
            end
            S_INS_RD: begin
                o_cmd.rd_en     = 1'b1;
                o_cmd.rd_addr_a = addr(r_a, r_b);
                o_cmd.rd_addr_b = addr(r_b, r_a);
                n_state         = S_INS_WA;
            end
            S_INS_WA: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_addr = addr(r_a, r_b);
                o_cmd.wr_sel  = WS_EDGE_A;
                o_cmd.cap     = CAP_EDGE;
                n_state       = S_INS_WB;
            end
            S_INS_WB: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_addr = addr(r_b, r_a);
                o_cmd.wr_sel  = WS_EDGE_B;
                n_state       = S_P0;
            end
            S_P0: begin
                o_cmd.rd_en     = 1'b1;
                o_cmd.rd_addr_a = addr(r_i, rk_a);
                o_cmd.rd_addr_b = addr(r_i, rk_b);
                n_state         = S_P1;
            end
            S_P1: begin
                o_cmd.rd_en     = 1'b1;
                o_cmd.rd_addr_a = addr(rk_b, r_j);
                o_cmd.rd_addr_b = addr(rk_a, r_j);
                o_cmd.cap       = CAP_S;
                n_state         = S_P2;
            end
            S_P2: begin
                o_cmd.rd_en     = 1'b1;
                o_cmd.rd_addr_a = addr(r_i, r_j);
                o_cmd.rd_addr_b = addr(r_i, r_j);
                o_cmd.cap       = CAP_C;
                n_state         = S_P3;
            end
            S_P3: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_addr = addr(r_i, r_j);
                o_cmd.wr_sel  = WS_RELAX;
                n_state       = S_P0;
                if (j_last) begin
                    n_j = '0;
                    if (i_last) begin
                        n_i = '0;
                        if (!r_clo || k_last) n_state = S_IDLE;
                        else n_k = r_k + NODE_W'(1);
                    end else begin
                        n_i = r_i + NODE_W'(1);
                    end
                end else begin
                    n_j = r_j + NODE_W'(1);
                end
            end
            S_QRY_RD: begin
                o_cmd.rd_en     = 1'b1;
                o_cmd.rd_addr_a = addr(r_a, r_b);
                o_cmd.rd_addr_b = addr(r_a, r_b);
                n_state         = S_QRY_OUT;
            end
            S_QRY_OUT: begin
                o_cmd.q_out = 1'b1;
                o_cmd.q_ok  = r_ok;
                n_state     = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_active <= CFG_W'(256);
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            if (i_cfg_valid) begin
                r_active <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_a   <= n_a;
        r_b   <= n_b;
        r_i   <= n_i;
        r_j   <= n_j;
        r_k   <= n_k;
        r_ok  <= n_ok;
        r_clo <= n_clo;
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    `APSP_ASSERT(a_p3_after_p2, r_state == S_P3 |-> $past(r_state) == S_P2)
    `APSP_ASSERT(a_qout_after_rd, o_cmd.q_out |-> $past(r_state) == S_QRY_RD)
    `APSP_NEVER(a_wr_with_q, o_cmd.wr_en && o_cmd.q_out)
endmodule

### rtl/all_pairs_shortest_path_engine.sv
// Top level of the all-pairs shortest path engine.
// Instantiates apsp_ctrl and apsp_dpath; depends on apsp_pkg.
//
// Usage:
//   Requests enter on start while busy is low: set edge, closure, insert edge
//   or query, with i_node_a, i_node_b and i_edge_weight.
//   A query answers on o_path_length / o_unreachable with o_valid high for
//   one cycle, registered after S_QRY_RD and S_QRY_OUT; the receiver cannot
//   stall. Other requests give no answer.
//   Insert edge relaxes every entry over the active nodes once; closure
//   relaxes every entry once per active node k. Each matrix entry relaxation
//   steps through S_P0 to S_P3 on the single write port of the distance memory.
//   Ignored edge requests and a closure over no nodes never raise busy.
//   The active node count is written over the i_cfg_valid / o_cfg_ready
//   channel; the user must write it only while the engine is idle, the block
//   does not enforce it. After reset the engine sweeps all 65536 distance memory
//   entries, one per cycle, with busy high; configuration writes are taken as ever.
`timescale 1ns / 1ps
module all_pairs_shortest_path_engine import apsp_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [REQ_W-1:0]       i_req_type,
    input  logic [PORT_NODE_W-1:0] i_node_a,
    input  logic [PORT_NODE_W-1:0] i_node_b,
    input  logic [WGT_W-1:0]       i_edge_weight,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_W-1:0]       i_cfg_data,
    output logic                   o_valid,
    output logic [LEN_W-1:0]       o_path_length,
    output logic                   o_unreachable
);
    t_dp_cmd cmd;

    apsp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_req_type  (i_req_type),
        .i_node_a    (i_node_a),
        .i_node_b    (i_node_b),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_busy      (busy),
        .o_cmd       (cmd)
    );

    apsp_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_edge_weight (i_edge_weight),
        .o_path_length (o_path_length),
        .o_unreachable (o_unreachable),
        .o_valid       (o_valid)
    );
endmodule
